/* src/tcg_pkg.sv */
// Shared types and constants of the text console glyph renderer.
`default_nettype none

package tcg_pkg;

  localparam int GLYPH_ROWS       = 16;
  localparam int MAX_SCREEN_WIDTH = 4096;
  localparam int HEIGHT_LIMIT     = 4096;
  localparam int CELL_W           = 8;

  localparam int FONT_DEPTH = 256 * GLYPH_ROWS;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int ROW_AW     = $clog2(GLYPH_ROWS);
  localparam int CUR_W      = 21;
  localparam int CNT_W      = $clog2(CUR_W);
  localparam int EW_W       = $clog2(MAX_SCREEN_WIDTH + 1);
  localparam int COL_W      = $clog2(MAX_SCREEN_WIDTH);
  localparam int LINE_W     = CUR_W - $clog2(CELL_W);
  localparam int ROWS_W     = $clog2(HEIGHT_LIMIT / GLYPH_ROWS + 1);
  localparam int LIM_W      = EW_W + ROWS_W;
  localparam int CFG_W      = 13;
  localparam int PIX_W      = 12;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic KIND_DRAW  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] font_bits;
  } tcg_in_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [7:0]       row_mask;
    logic             last;
  } tcg_out_t;

  // What one printed character asks of the row sequencer
  typedef struct packed {
    logic             clear;
    logic             draw;
    logic [7:0]       glyph;
    logic [PIX_W-1:0] org_x;
    logic [PIX_W-1:0] org_y;
  } tcg_step_t;

endpackage

`default_nettype wire

/* src/tcg_font_ram.sv */
// Font store: one byte per glyph row, one write port and one registered read port.
`default_nettype none

module tcg_font_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tcg_pkg::FONT_AW-1:0] waddr,
  input  wire logic [7:0]                  wdata,
  input  wire logic                        re,
  input  wire logic [tcg_pkg::FONT_AW-1:0] raddr,
  output logic      [7:0]                  rdata
);
  import tcg_pkg::*;

  logic [7:0] mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read so a stalled row is not lost
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/tcg_div.sv */
// Bit-serial restoring divider: splits the cursor into text line and column.
`default_nettype none

module tcg_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tcg_pkg::CUR_W-1:0] dividend,
  input  wire logic [tcg_pkg::EW_W-1:0]  divisor,
  output logic                           busy,
  output logic                           done,
  output logic      [tcg_pkg::CUR_W-1:0] quotient,
  output logic      [tcg_pkg::EW_W-1:0]  remainder
);
  import tcg_pkg::*;

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [EW_W-1:0]  rem;
  logic [CUR_W-1:0] quo;
  logic [EW_W-1:0]  dvs;
  logic [EW_W:0]    trial;
  logic [EW_W:0]    diff;
  logic             take;

  always_comb begin
    trial = {rem, quo[CUR_W-1]};
    diff  = trial - {1'b0, dvs};
    take  = ~diff[EW_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (run) begin
        rem <= take ? diff[EW_W-1:0] : trial[EW_W-1:0];
        quo <= {quo[CUR_W-2:0], take};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(CUR_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign busy      = run;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

/* src/tcg_cursor.sv */
// Screen geometry registers and cursor, kept as linear position, column and text line.
`default_nettype none

module tcg_cursor (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_idx,
  input  wire logic [tcg_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      step_en,
  input  wire logic [7:0]                step_char,
  output tcg_pkg::tcg_step_t             step,
  output logic                           busy
);
  import tcg_pkg::*;

  localparam int OYP_W = LINE_W + ROW_AW + 1;

  logic [CFG_W-1:0]  screen_width;
  logic [CFG_W-1:0]  screen_height;
  logic [CUR_W-1:0]  cursor;
  logic [COL_W-1:0]  col;
  logic [LINE_W-1:0] line;
  logic [LIM_W-1:0]  limit;
  logic              start_q;

  logic [CFG_W-1:0]  wc;
  logic [CFG_W-1:0]  hc;
  logic [EW_W-1:0]   w_eff;
  logic [ROWS_W-1:0] rows;

  logic              div_busy;
  logic              div_done;
  logic [CUR_W-1:0]  div_quo;
  logic [EW_W-1:0]   div_rem;

  logic              clr;
  logic [CUR_W-1:0]  c0;
  logic [CUR_W-1:0]  cursor_next;
  logic [COL_W-1:0]  col0;
  logic [COL_W-1:0]  col_next;
  logic [COL_W-1:0]  ox;
  logic [LINE_W-1:0] ln0;
  logic [LINE_W-1:0] line_next;
  logic [LINE_W-1:0] oy_line;
  logic [EW_W-1:0]   col_inc;
  logic [OYP_W-1:0]  oy_prod;
  logic              draw;
  logic [7:0]        glyph;

  // Clamp the geometry registers to the usable range
  always_comb begin
    if (screen_width < CFG_W'(CELL_W)) begin
      wc = CFG_W'(CELL_W);
    end else if (32'(screen_width) > MAX_SCREEN_WIDTH) begin
      wc = CFG_W'(MAX_SCREEN_WIDTH);
    end else begin
      wc = screen_width;
    end
    w_eff = EW_W'(wc) & ~EW_W'(CELL_W - 1);

    if (screen_height < CFG_W'(GLYPH_ROWS)) begin
      hc = CFG_W'(GLYPH_ROWS);
    end else if (32'(screen_height) > HEIGHT_LIMIT) begin
      hc = CFG_W'(HEIGHT_LIMIT);
    end else begin
      hc = screen_height;
    end
    rows = ROWS_W'(hc / GLYPH_ROWS);
  end

  tcg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (start_q),
    .dividend  (cursor),
    .divisor   (w_eff),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    clr  = LIM_W'(cursor) >= limit;
    c0   = clr ? '0 : cursor;
    col0 = clr ? '0 : col;
    ln0  = clr ? '0 : line;

    col_inc     = EW_W'(col0) + EW_W'(CELL_W);
    cursor_next = c0;
    col_next    = col0;
    line_next   = ln0;
    draw        = 1'b0;
    glyph       = step_char;
    ox          = col0;
    oy_line     = ln0;

    case (step_char)
      CH_NL: begin
        cursor_next = c0 + CUR_W'(w_eff) - CUR_W'(col0);
        col_next    = '0;
        line_next   = ln0 + LINE_W'(1);
      end
      CH_CR: begin
        cursor_next = c0 - CUR_W'(col0);
        col_next    = '0;
      end
      CH_BS: begin
        // Drop the backspace at home; otherwise step back and blank the cell
        if (c0 >= CUR_W'(CELL_W)) begin
          cursor_next = c0 - CUR_W'(CELL_W);
          draw        = 1'b1;
          glyph       = CH_SPACE;
          if (col0 == '0) begin
            col_next  = COL_W'(w_eff - EW_W'(CELL_W));
            line_next = ln0 - LINE_W'(1);
          end else begin
            col_next  = col0 - COL_W'(CELL_W);
          end
          ox      = col_next;
          oy_line = line_next;
        end
      end
      default: begin
        draw        = 1'b1;
        cursor_next = c0 + CUR_W'(CELL_W);
        if (col_inc == w_eff) begin
          col_next  = '0;
          line_next = ln0 + LINE_W'(1);
        end else begin
          col_next  = COL_W'(col_inc);
        end
      end
    endcase

    oy_prod = OYP_W'(oy_line) * OYP_W'(GLYPH_ROWS);

    step.clear = clr;
    step.draw  = draw;
    step.glyph = glyph;
    step.org_x = PIX_W'(ox);
    step.org_y = oy_prod[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
      cursor        <= '0;
      col           <= '0;
      line          <= '0;
      start_q       <= 1'b0;
    end else begin
      start_q <= cfg_we;
      if (cfg_we) begin
        case (cfg_idx)
          REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
          REG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
          default:           screen_width  <= screen_width;
        endcase
      end
      if (div_done) begin
        col  <= COL_W'(div_rem);
        line <= LINE_W'(div_quo);
      end else if (step_en) begin
        cursor <= cursor_next;
        col    <= col_next;
        line   <= line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit <= LIM_W'(w_eff) * LIM_W'(rows);
  end

  // Hold off characters while the column and line are rebuilt after a geometry write
  assign busy = start_q | div_busy | div_done;

endmodule

`default_nettype wire

/* src/text_console_glyph_renderer.sv */
// Top level of the text console glyph renderer: row sequencer, font store and output register.
//
//   channel  dir  word          handshake
//   in       in   tcg_in_t      in_valid / in_ready
//   out      out  tcg_out_t     out_valid / out_ready
//   cfg      in   index + data  cfg_valid / cfg_ready (always ready)
//
// A printed character is accepted, then the font store is read once per glyph row, after a
// clear-screen word if one goes first. Font loads, newline, carriage return and a backspace
// at home read no glyph rows; all but font loads still send a clear-screen word when one
// goes first. A geometry write stalls the input while a bit-serial divider rebuilds the
// cursor column and line. Reset is synchronous; the font store is not cleared.
// A stalled output holds its word while the next read waits in the stage behind it.
`default_nettype none

module text_console_glyph_renderer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire tcg_pkg::tcg_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tcg_pkg::tcg_out_t              out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [tcg_pkg::CFG_W-1:0] cfg_data
);
  import tcg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } tcg_state_t;

  tcg_state_t        st;
  tcg_step_t         step;
  logic              busy;
  logic              in_acc;
  logic              cfg_acc;
  logic              print_acc;

  logic              job_clear;
  logic              job_draw;
  logic [7:0]        job_glyph;
  logic [PIX_W-1:0]  job_x;
  logic [PIX_W-1:0]  job_y;
  logic [ROW_AW-1:0] row_cnt;

  logic              p_valid;
  logic              p_kind;
  logic [PIX_W-1:0]  p_x;
  logic [PIX_W-1:0]  p_y;
  logic              p_last;

  logic              move;
  logic              slot_go;
  logic              issue;
  logic              last_row;

  logic              ram_we;
  logic [FONT_AW-1:0] ram_waddr;
  logic              ram_re;
  logic [FONT_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_ready  = (st == ST_IDLE) & ~busy;
  assign in_acc    = in_valid & in_ready;
  assign print_acc = in_acc & (in_data.opcode == OP_PRINT);

  tcg_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_acc),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .step_en   (print_acc),
    .step_char (in_data.char_code),
    .step      (step),
    .busy      (busy)
  );

  // Font rows beyond the glyph height are dropped
  assign ram_we    = in_acc & (in_data.opcode == OP_LOAD) &
                     ({2'b00, in_data.glyph_row} < 6'(GLYPH_ROWS));
  assign ram_waddr = FONT_AW'(in_data.char_code) * FONT_AW'(GLYPH_ROWS) +
                     FONT_AW'(in_data.glyph_row);
  assign ram_raddr = FONT_AW'(job_glyph) * FONT_AW'(GLYPH_ROWS) + FONT_AW'(row_cnt);

  assign move     = p_valid & (~out_valid | out_ready);
  assign slot_go  = ~p_valid | move;
  assign issue    = (st == ST_RUN) & slot_go;
  assign ram_re   = issue & ~job_clear;
  assign last_row = row_cnt == ROW_AW'(GLYPH_ROWS - 1);

  tcg_font_ram u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.font_bits),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: one output word per slot, clear first, then the glyph rows
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      job_clear <= 1'b0;
      job_draw  <= 1'b0;
      row_cnt   <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (print_acc) begin
            job_clear <= step.clear;
            job_draw  <= step.draw;
            row_cnt   <= '0;
            if (step.clear | step.draw) begin
              st <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (job_clear) begin
              job_clear <= 1'b0;
              if (~job_draw) begin
                st <= ST_IDLE;
              end
            end else begin
              row_cnt <= row_cnt + ROW_AW'(1);
              if (last_row) begin
                st <= ST_IDLE;
              end
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (print_acc) begin
      job_glyph <= step.glyph;
      job_x     <= step.org_x;
      job_y     <= step.org_y;
    end
  end

  // Read stage: word fields wait here for the font byte
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (issue) begin
      p_valid <= 1'b1;
    end else if (move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      if (job_clear) begin
        p_kind <= KIND_CLEAR;
        p_x    <= '0;
        p_y    <= '0;
        p_last <= ~job_draw;
      end else begin
        p_kind <= KIND_DRAW;
        p_x    <= job_x;
        p_y    <= job_y + PIX_W'(row_cnt);
        p_last <= last_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data.kind     <= p_kind;
      out_data.pixel_x  <= p_x;
      out_data.pixel_y  <= p_y;
      out_data.row_mask <= (p_kind == KIND_CLEAR) ? 8'h00 : ram_rdata;
      out_data.last     <= p_last;
    end
  end

endmodule

`default_nettype wire

/* src/tcg_checker.sv */
// Port-level checks on the text console glyph renderer, bound to the top level.
`default_nettype none

module tcg_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire tcg_pkg::tcg_out_t         out_data,
  input wire logic                      cfg_valid,
  input wire logic                      cfg_ready
);
  import tcg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed or dropped while stalled");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_CLEAR |->
      out_data.pixel_x == '0 && out_data.pixel_y == '0 && out_data.row_mask == 8'h00)
    else $error("clear word carries non-zero fields");

  a_cell_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DRAW |->
      out_data.pixel_x[$clog2(CELL_W)-1:0] == '0)
    else $error("glyph row not on a cell boundary");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken while cursor is rebuilt after a geometry write");

endmodule

bind text_console_glyph_renderer tcg_checker u_tcg_checker (.*);

`default_nettype wire

/* sim/text_console_glyph_renderer_tb.sv */
// Self-checking testbench of the text console glyph renderer: random stimulus, scoreboard.
`default_nettype none

module text_console_glyph_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcg_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 63;
  localparam int NUM_PHASES    = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid  = 1'b0;
  logic              in_ready;
  tcg_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tcg_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_W-1:0]  cfg_data  = '0;

  // Handshakes seen at the last rising edge
  logic in_took  = 1'b0;
  logic out_took = 1'b0;
  logic cfg_took = 1'b0;

  tcg_in_t  feed_words[$];
  tcg_out_t due_words[$];

  // Shadow of the block: geometry, cursor and font
  int unsigned scr_width;
  int unsigned scr_height;
  int unsigned cursor_pos;
  logic [7:0]  font_copy [FONT_DEPTH];

  // Stimulus side bookkeeping: font rows already loaded, glyphs ready to print
  bit          row_known [FONT_DEPTH];
  logic [7:0]  glyph_set[$];
  int          fresh_count = 0;

  int          errors  = 0;
  int          stalled = 0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  bit          in_calm  = 1'b0;
  bit          out_calm = 1'b0;

  int unsigned phase_w [NUM_PHASES] = '{0, 8191, 37, 4096, 640, 24, 120};
  int unsigned phase_h [NUM_PHASES] = '{0, 8191, 50, 17, 480, 15, 4100};

  text_console_glyph_renderer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned pick_gap(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic draw_glyph_rows(input logic [7:0] ch, input int unsigned eff_w,
                                 ref tcg_out_t rows[$]);
    tcg_out_t    r;
    int unsigned px;
    int unsigned py;
    px = cursor_pos % eff_w;
    py = (cursor_pos / eff_w) * GLYPH_ROWS;
    for (int i = 0; i < GLYPH_ROWS; i++) begin
      r          = '0;
      r.kind     = KIND_DRAW;
      r.pixel_x  = PIX_W'(px);
      r.pixel_y  = PIX_W'(py + i);
      r.row_mask = font_copy[ch * GLYPH_ROWS + i];
      rows.push_back(r);
    end
  endtask

  // Work out the words one accepted item causes and queue them as due
  task automatic render_step(input tcg_in_t w);
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned lim;
    tcg_out_t    rows[$];
    tcg_out_t    r;
    if (w.opcode == OP_LOAD) begin
      if (w.glyph_row < GLYPH_ROWS) font_copy[w.char_code * GLYPH_ROWS + w.glyph_row] = w.font_bits;
      return;
    end
    eff_w = scr_width;
    if (eff_w < CELL_W) eff_w = CELL_W;
    if (eff_w > MAX_SCREEN_WIDTH) eff_w = MAX_SCREEN_WIDTH;
    eff_w -= eff_w % CELL_W;
    eff_h = scr_height;
    if (eff_h < GLYPH_ROWS) eff_h = GLYPH_ROWS;
    if (eff_h > HEIGHT_LIMIT) eff_h = HEIGHT_LIMIT;
    lim = eff_w * (eff_h / GLYPH_ROWS);

    if (cursor_pos >= lim) begin
      r      = '0;
      r.kind = KIND_CLEAR;
      rows.push_back(r);
      cursor_pos = 0;
    end

    case (w.char_code)
      CH_NL: begin
        cursor_pos += eff_w;
        cursor_pos -= cursor_pos % eff_w;
      end
      CH_CR: cursor_pos -= cursor_pos % eff_w;
      CH_BS: begin
        if (cursor_pos >= CELL_W) begin
          cursor_pos -= CELL_W;
          draw_glyph_rows(CH_SPACE, eff_w, rows);
        end
      end
      default: begin
        draw_glyph_rows(w.char_code, eff_w, rows);
        cursor_pos += CELL_W;
      end
    endcase
    cursor_pos = cursor_pos % (1 << CUR_W);

    foreach (rows[j]) begin
      r      = rows[j];
      r.last = (j == rows.size() - 1);
      due_words.push_back(r);
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Scoreboard, shadow update and watchdog
  always @(posedge clk) begin
    tcg_out_t due;
    in_took  <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst) begin
      cursor_pos = 0;
      scr_width  = RESET_WIDTH;
      scr_height = RESET_HEIGHT;
      stalled    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $display("%0t: word with nothing due: expected none got %h", $time, out_data);
          errors++;
        end else begin
          due = due_words.pop_front();
          check_field("kind", due.kind, out_data.kind);
          check_field("pixel_x", due.pixel_x, out_data.pixel_x);
          check_field("pixel_y", due.pixel_y, out_data.pixel_y);
          check_field("row_mask", due.row_mask, out_data.row_mask);
          check_field("last", due.last, out_data.last);
        end
      end
      if (in_valid && in_ready) render_step(in_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_WIDTH) scr_width = cfg_data;
        else scr_height = cfg_data;
      end

      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stalled <= 0;
      end else if (stalled >= STALL_LIMIT) begin
        $display("FAIL text_console_glyph_renderer");
        $finish;
      end else begin
        stalled <= stalled + 1;
      end
    end
  end

  // Input driver: present the next word, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else if (!in_valid || in_took) begin
      if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (feed_words.size() != 0) begin
        in_data  <= feed_words.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) in_calm <= !in_calm;
        in_wait  <= pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: stall for a random number of cycles after each word
  always @(negedge clk) begin
    int unsigned g;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_took) begin
      if ($urandom_range(0, 29) == 0) out_calm <= !out_calm;
      g = pick_gap(out_calm);
      out_ready <= (g == 0);
      out_wait  <= g;
    end else begin
      if (out_wait != 0) out_wait <= out_wait - 1;
      out_ready <= (out_wait <= 1);
    end
  end

  task automatic queue_load(input logic [7:0] ch, input logic [3:0] row, input logic [7:0] bits);
    tcg_in_t w;
    w.opcode    = OP_LOAD;
    w.char_code = ch;
    w.glyph_row = row;
    w.font_bits = bits;
    row_known[ch * GLYPH_ROWS + row] = 1'b1;
    feed_words.push_back(w);
  endtask

  task automatic queue_print(input logic [7:0] ch);
    tcg_in_t w;
    w.opcode    = OP_PRINT;
    w.char_code = ch;
    w.glyph_row = 4'($urandom_range(0, 15));
    w.font_bits = 8'($urandom_range(0, 255));
    feed_words.push_back(w);
  endtask

  // Load whatever rows of a glyph are still missing before it is printed
  task automatic ensure_glyph(input logic [7:0] ch, output int added);
    added = 0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      if (!row_known[ch * GLYPH_ROWS + r]) begin
        queue_load(ch, 4'(r), 8'($urandom_range(0, 255)));
        added++;
      end
    end
  endtask

  task automatic queue_random(input int n);
    int          k;
    int          added;
    int unsigned pick;
    logic [7:0]  ch;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_print(CH_NL);
        k++;
      end else if (pick < 12) begin
        queue_print(CH_CR);
        k++;
      end else if (pick < 18) begin
        queue_print(CH_BS);
        k++;
      end else if (pick < 24) begin
        // stray row load, any glyph and row
        queue_load(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 255)));
        k++;
      end else begin
        if (fresh_count < 2 || (glyph_set.size() < 24 && $urandom_range(0, 4) == 0)) begin
          if (fresh_count == 0) ch = 8'h00;
          else if (fresh_count == 1) ch = 8'hFF;
          else begin
            do ch = 8'($urandom_range(0, 255));
            while (ch == CH_NL || ch == CH_CR || ch == CH_BS);
          end
          fresh_count++;
          glyph_set.push_back(ch);
        end else begin
          ch = glyph_set[$urandom_range(0, glyph_set.size() - 1)];
        end
        ensure_glyph(ch, added);
        queue_print(ch);
        k += added + 1;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every word is taken and every due word has come, then let the block go idle
  task automatic drain();
    while (feed_words.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Two columns by two text rows
    write_reg(REG_SCREEN_WIDTH, 16);
    write_reg(REG_SCREEN_HEIGHT, 32);
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      case (r)
        0:       queue_load(CH_SPACE, 4'(r), 8'h00);
        1:       queue_load(CH_SPACE, 4'(r), 8'hFF);
        2:       queue_load(CH_SPACE, 4'(r), 8'h80);
        3:       queue_load(CH_SPACE, 4'(r), 8'h01);
        default: queue_load(CH_SPACE, 4'(r), 8'($urandom_range(0, 255)));
      endcase
    end
    glyph_set.push_back(CH_SPACE);
    queue_print(CH_BS);     // at home: no word
    queue_print(CH_SPACE);
    queue_print(CH_BS);     // redraw a space at the origin
    queue_print(CH_SPACE);
    queue_print(CH_CR);
    queue_print(CH_NL);
    queue_print(CH_SPACE);
    queue_print(CH_SPACE);  // cursor now past the last text row
    queue_print(CH_NL);     // clear first, then move down
    queue_print(CH_SPACE);
    queue_print(CH_SPACE);
    queue_print(CH_BS);     // clear, then nothing at home
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_SCREEN_WIDTH, phase_w[p]);
      write_reg(REG_SCREEN_HEIGHT, phase_h[p]);
      queue_random(PHASE_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("PASS text_console_glyph_renderer");
    end else begin
      $display("FAIL text_console_glyph_renderer");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* text_console_glyph_renderer.f */
src/tcg_pkg.sv
src/tcg_font_ram.sv
src/tcg_div.sv
src/tcg_cursor.sv
src/text_console_glyph_renderer.sv
src/tcg_checker.sv
sim/text_console_glyph_renderer_tb.sv
